// ===== design/md5_pkg.sv =====
`default_nettype none

package md5_pkg;

   localparam int STEP_W = 4;
   localparam int POS_W = 6;
   localparam int ROUNDS = 64;

   // Byte position at which the length field starts.
   localparam logic [POS_W-1:0] PAD_END_POS = 6'd56;
   localparam logic [POS_W-1:0] BLOCK_LAST_POS = 6'd63;
   localparam logic [3:0] LEN_LO_WORD = 4'd14;
   localparam logic [3:0] LEN_HI_WORD = 4'd15;
   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] CHAIN_INIT [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   typedef enum logic [3:0] {
      OP_ACCEPT,
      OP_PAD80,
      OP_PADZ,
      OP_LENLO,
      OP_LENHI,
      OP_EMIT,
      OP_REINIT,
      OP_CRD,
      OP_CLOAD,
      OP_ROUND,
      OP_CFIN
   } opcode_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_STAY_IDLE,
      JMP_AT_END,
      JMP_NOT_END,
      JMP_ROUNDS_LEFT,
      JMP_EMIT_BUSY,
      JMP_RETURN
   } jump_type;

   typedef enum logic [1:0] {
      CALL_NONE,
      CALL_FULL,
      CALL_ALWAYS
   } call_type;

   typedef struct packed {
      opcode_type        op;
      jump_type          jump;
      call_type          call;
      logic [STEP_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic accepted_end;
      logic byte_full;
      logic pos_at_end;
      logic rounds_done;
      logic emit_done;
   } status_type;

   localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
   localparam logic [STEP_W-1:0] STEP_PAD80 = 4'd1;
   localparam logic [STEP_W-1:0] STEP_PADZ = 4'd2;
   localparam logic [STEP_W-1:0] STEP_LENLO = 4'd3;
   localparam logic [STEP_W-1:0] STEP_LENHI = 4'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT = 4'd5;
   localparam logic [STEP_W-1:0] STEP_REINIT = 4'd6;
   localparam logic [STEP_W-1:0] STEP_CRD = 4'd7;
   localparam logic [STEP_W-1:0] STEP_CLOAD = 4'd8;
   localparam logic [STEP_W-1:0] STEP_ROUND = 4'd9;
   localparam logic [STEP_W-1:0] STEP_CFIN = 4'd10;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         STEP_IDLE:   w = '{OP_ACCEPT, JMP_STAY_IDLE, CALL_FULL, STEP_IDLE};
         STEP_PAD80:  w = '{OP_PAD80, JMP_AT_END, CALL_FULL, STEP_LENLO};
         STEP_PADZ:   w = '{OP_PADZ, JMP_NOT_END, CALL_FULL, STEP_PADZ};
         STEP_LENLO:  w = '{OP_LENLO, JMP_NEXT, CALL_NONE, STEP_IDLE};
         STEP_LENHI:  w = '{OP_LENHI, JMP_NEXT, CALL_ALWAYS, STEP_IDLE};
         STEP_EMIT:   w = '{OP_EMIT, JMP_EMIT_BUSY, CALL_NONE, STEP_EMIT};
         STEP_REINIT: w = '{OP_REINIT, JMP_ALWAYS, CALL_NONE, STEP_IDLE};
         STEP_CRD:    w = '{OP_CRD, JMP_NEXT, CALL_NONE, STEP_IDLE};
         STEP_CLOAD:  w = '{OP_CLOAD, JMP_NEXT, CALL_NONE, STEP_IDLE};
         STEP_ROUND:  w = '{OP_ROUND, JMP_ROUNDS_LEFT, CALL_NONE, STEP_ROUND};
         STEP_CFIN:   w = '{OP_CFIN, JMP_RETURN, CALL_NONE, STEP_IDLE};
         default:     w = '{OP_REINIT, JMP_ALWAYS, CALL_NONE, STEP_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] round_s(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd7;
      endcase
      return s;
   endfunction

   // Message word used by round i.
   function automatic logic [3:0] round_g(input logic [5:0] i);
      logic [3:0] g;
      case (i[5:4])
         2'd0:    g = i[3:0];
         2'd1:    g = 4'(5 * i + 1);
         2'd2:    g = 4'(3 * i + 5);
         default: g = 4'(7 * i);
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

// ===== design/md5_seq.sv =====
`default_nettype none

module md5_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire md5_pkg::status_type  status,
   output md5_pkg::ucode_type        uc
);

   logic [md5_pkg::STEP_W-1:0] step_ff, step_in;
   logic [md5_pkg::STEP_W-1:0] ret_ff, ret_in;
   logic [md5_pkg::STEP_W-1:0] nxt;
   logic                       taken;
   logic                       call;

   assign uc = md5_pkg::ucode_rom(step_ff);

   always_comb begin
      unique case (uc.jump)
         md5_pkg::JMP_NEXT:        taken = 1'b0;
         md5_pkg::JMP_ALWAYS:      taken = 1'b1;
         md5_pkg::JMP_STAY_IDLE:   taken = !status.accepted_end;
         md5_pkg::JMP_AT_END:      taken = status.pos_at_end;
         md5_pkg::JMP_NOT_END:     taken = !status.pos_at_end;
         md5_pkg::JMP_ROUNDS_LEFT: taken = !status.rounds_done;
         md5_pkg::JMP_EMIT_BUSY:   taken = !status.emit_done;
         md5_pkg::JMP_RETURN:      taken = 1'b1;
         default:                  taken = 1'b0;
      endcase

      if (uc.jump == md5_pkg::JMP_RETURN) begin
         nxt = ret_ff;
      end else if (taken) begin
         nxt = uc.target;
      end else begin
         nxt = step_ff + 1'b1;
      end

      unique case (uc.call)
         md5_pkg::CALL_FULL:   call = status.byte_full;
         md5_pkg::CALL_ALWAYS: call = 1'b1;
         default:              call = 1'b0;
      endcase

      // A call runs the compression routine and comes back to the step that
      // would have followed.
      if (call) begin
         step_in = md5_pkg::STEP_CRD;
         ret_in = nxt;
      end else begin
         step_in = nxt;
         ret_in = ret_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= md5_pkg::STEP_IDLE;
         ret_ff <= md5_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
         ret_ff <= ret_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/md5_hash_engine.sv =====
// Each message byte is taken while req_stall is low; a byte completing a 64-byte block is
// followed by compression (one round per cycle) during which req_stall is high.
// After an end item, padding runs one byte per cycle outside compression and the block is
// compressed once or twice before the first digest word appears; the four words follow
// at one per cycle when rsp_stall is low, and a final step then re-initializes the hash.
// Synchronous reset loads the initial chaining words and clears the bit count.
`default_nettype none

module md5_hash_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [1:0]       rsp_word_index,
   output logic             rsp_final_word
);

   md5_pkg::ucode_type  uc;
   md5_pkg::status_type status;

   logic [md5_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [63:0]               bit_count_ff, bit_count_in;
   logic [31:0]               word_ff, word_in;
   logic [31:0]               chain_ff [4];
   logic [31:0]               chain_in [4];
   logic [31:0]               work_ff [4];
   logic [31:0]               work_in [4];
   logic [31:0]               pre_ff, pre_in;
   logic [5:0]                rnd_ff, rnd_in;
   logic [1:0]                emit_k_ff, emit_k_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_word_ff, rsp_word_in;
   logic [1:0]                rsp_index_ff, rsp_index_in;
   logic                      rsp_final_ff, rsp_final_in;

   logic [31:0] mem [16];
   logic [31:0] rdata_ff;
   logic [3:0]  rd_addr;
   logic        wr_en;
   logic [3:0]  wr_addr;
   logic [31:0] wr_data;

   logic        accept;
   logic        byte_we;
   logic [7:0]  byte_val;
   logic        out_load;
   logic [31:0] f_val;
   logic [31:0] sum;
   logic [63:0] rot_wide;
   logic [5:0]  rnd_next;
   logic [5:0]  rnd_ahead;

   md5_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uc     (uc)
   );

   assign req_stall = (uc.op != md5_pkg::OP_ACCEPT);
   assign accept = req_valid && (uc.op == md5_pkg::OP_ACCEPT);
   assign out_load = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index = rsp_index_ff;
   assign rsp_final_word = rsp_final_ff;

   assign rnd_next = rnd_ff + 6'd1;
   assign rnd_ahead = rnd_ff + 6'd2;

   // Round function: the addend that excludes f is registered in pre_ff ahead of its round.
   always_comb begin
      case (rnd_ff[5:4])
         2'd0:    f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         2'd1:    f_val = (work_ff[1] & work_ff[3]) | (work_ff[2] & ~work_ff[3]);
         2'd2:    f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         default: f_val = work_ff[2] ^ (work_ff[1] | ~work_ff[3]);
      endcase
      sum = pre_ff + f_val;
      rot_wide = {sum, sum} << md5_pkg::round_s(rnd_ff);
   end

   always_comb begin
      pos_in = pos_ff;
      bit_count_in = bit_count_ff;
      word_in = word_ff;
      chain_in = chain_ff;
      work_in = work_ff;
      pre_in = pre_ff;
      rnd_in = rnd_ff;
      emit_k_in = emit_k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_final_in = rsp_final_ff;
      byte_we = 1'b0;
      byte_val = 8'h00;
      wr_en = 1'b0;
      wr_addr = pos_ff[5:2];
      wr_data = 32'h0;
      rd_addr = md5_pkg::round_g(rnd_ahead);
      status = '0;

      unique case (uc.op)
         md5_pkg::OP_ACCEPT: begin
            byte_we = accept && req_byte_valid;
            byte_val = req_data_byte;
            status.accepted_end = accept && req_end_of_message;
         end
         md5_pkg::OP_PAD80: begin
            byte_we = 1'b1;
            byte_val = md5_pkg::PAD_MARK;
         end
         md5_pkg::OP_PADZ: begin
            byte_we = 1'b1;
         end
         md5_pkg::OP_LENLO: begin
            wr_en = 1'b1;
            wr_addr = md5_pkg::LEN_LO_WORD;
            wr_data = bit_count_ff[31:0];
         end
         md5_pkg::OP_LENHI: begin
            wr_en = 1'b1;
            wr_addr = md5_pkg::LEN_HI_WORD;
            wr_data = bit_count_ff[63:32];
         end
         md5_pkg::OP_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_word_in = chain_ff[emit_k_ff];
               rsp_index_in = emit_k_ff;
               rsp_final_in = (emit_k_ff == 2'd3);
               emit_k_in = emit_k_ff + 2'd1;
               status.emit_done = (emit_k_ff == 2'd3);
            end
         end
         md5_pkg::OP_REINIT: begin
            chain_in = md5_pkg::CHAIN_INIT;
            bit_count_in = 64'h0;
            pos_in = '0;
         end
         md5_pkg::OP_CRD: begin
            rd_addr = md5_pkg::round_g(6'd0);
         end
         md5_pkg::OP_CLOAD: begin
            rd_addr = md5_pkg::round_g(6'd1);
            work_in = chain_ff;
            pre_in = chain_ff[0] + md5_pkg::round_k(6'd0) + rdata_ff;
            rnd_in = 6'd0;
         end
         md5_pkg::OP_ROUND: begin
            // New a is the old d, so its addend can be summed now.
            work_in[0] = work_ff[3];
            work_in[1] = work_ff[1] + rot_wide[63:32];
            work_in[2] = work_ff[1];
            work_in[3] = work_ff[2];
            pre_in = work_ff[3] + md5_pkg::round_k(rnd_next) + rdata_ff;
            rnd_in = rnd_next;
            status.rounds_done = (rnd_ff == 6'(md5_pkg::ROUNDS - 1));
         end
         md5_pkg::OP_CFIN: begin
            for (int j = 0; j < 4; j++) begin
               chain_in[j] = chain_ff[j] + work_ff[j];
            end
         end
         default: begin
         end
      endcase

      if (byte_we) begin
         word_in[{pos_ff[1:0], 3'b000} +: 8] = byte_val;
         pos_in = pos_ff + 1'b1;
         status.byte_full = (pos_ff == md5_pkg::BLOCK_LAST_POS);
         status.pos_at_end = (pos_in == md5_pkg::PAD_END_POS);
         if (pos_ff[1:0] == 2'd3) begin
            wr_en = 1'b1;
            wr_data = {byte_val, word_ff[23:0]};
         end
         if (uc.op == md5_pkg::OP_ACCEPT) begin
            bit_count_in = bit_count_ff + 64'd8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         bit_count_ff <= 64'h0;
         chain_ff <= md5_pkg::CHAIN_INIT;
         emit_k_ff <= 2'd0;
         rnd_ff <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         bit_count_ff <= bit_count_in;
         chain_ff <= chain_in;
         emit_k_ff <= emit_k_in;
         rnd_ff <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      work_ff <= work_in;
      pre_ff <= pre_in;
      rsp_word_ff <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_final_ff <= rsp_final_in;
   end

   // An end transaction starts padding, so nothing is taken in the next cycle.
   a_end_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_end_of_message) |=> req_stall)
      else $error("input taken right after an end transaction");

   // Compression only starts on a block boundary or after the length words.
   a_compress_aligned: assert property (@(posedge clock) disable iff (reset)
      (uc.op == md5_pkg::OP_CRD) |-> (pos_ff == '0 || pos_ff == md5_pkg::PAD_END_POS))
      else $error("compression started at an unaligned byte position");

   a_final_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_final_ff == (rsp_index_ff == 2'd3)))
      else $error("final flag disagrees with word index");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(uc.op == md5_pkg::OP_EMIT))
      else $error("result raised outside the emit step");

   // The emit counter is back at word A whenever a message is being taken in.
   a_emit_count_idle: assert property (@(posedge clock) disable iff (reset)
      (uc.op == md5_pkg::OP_ACCEPT) |-> (emit_k_ff == 2'd0))
      else $error("digest word counter not reset between messages");

endmodule

`default_nettype wire

// ===== tb/tb_md5_hash_engine.sv =====
`default_nettype none

module tb_md5_hash_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 460;
   localparam int MIN_MESSAGES = 8;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;

   // Digests of "", "a" and "abc", word A in element 0.
   localparam logic [3:0][31:0] EMPTY_MD5 =
      {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4};
   localparam logic [3:0][31:0] A_MD5 =
      {32'h61267769, 32'he299c331, 32'ha8b6f1c0, 32'hb975c10c};
   localparam logic [3:0][31:0] ABC_MD5 =
      {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190};

   localparam logic [31:0] SINE_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };
   localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

   // Message lengths around the padding and block boundaries.
   localparam int EDGE_LEN [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

   typedef struct packed {
      logic [7:0]       data;
      logic             has_byte;
      logic             is_end;
      logic             typed;
      logic [3:0][31:0] digest;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 13;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_MD5},
      '{8'hff, 1'b0, 1'b0, 1'b0, '0},
      '{8'h61, 1'b1, 1'b1, 1'b1, A_MD5},
      '{8'h61, 1'b1, 1'b0, 1'b0, '0},
      '{8'h62, 1'b1, 1'b0, 1'b0, '0},
      '{8'ha5, 1'b0, 1'b0, 1'b0, '0},
      '{8'h63, 1'b1, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b1, 1'b1, ABC_MD5},
      '{8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{8'hff, 1'b1, 1'b0, 1'b0, '0},
      '{8'hff, 1'b1, 1'b1, 1'b0, '0},
      '{8'h5a, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_MD5}
   };

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  idx;
      logic        fin;
   } digest_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_final_word;

   md5_hash_engine dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_final_word     (rsp_final_word)
   );

   always #2 clock = ~clock;

   // Hash state mirrored by the testbench.
   logic [31:0] chain [4];
   logic [7:0]  blk_bytes [64];
   logic [63:0] bit_len;

   digest_word_type digest_fifo [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_asked = 0;
   int hold_done = 0;
   int hold_left = 0;
   int mismatches = 0;
   int words_checked = 0;
   int items_sent = 0;
   int bytes_sent = 0;
   int ignored_items = 0;
   int messages_sent = 0;
   int cycle_count = 0;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void chain_reset();
      chain[0] = 32'h67452301;
      chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476;
      bit_len = '0;
   endfunction

   function automatic void md5_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t;
      int g, r;
      for (int i = 0; i < 16; i++)
         w[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int i = 0; i < 64; i++) begin
         r = i / 16;
         case (r)
            0: begin
               f = (b & c) | (~b & d);
               g = i;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         t = d;
         d = c;
         c = b;
         b = b + rotl(a + f + SINE_K[i] + w[g], ROT_AMT[r * 4 + i % 4]);
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
   endfunction

   function automatic void md5_absorb(input logic [7:0] data);
      int pos;
      pos = int'(bit_len[8:3]);
      blk_bytes[pos] = data;
      bit_len += 64'd8;
      if (pos == 63)
         md5_compress();
   endfunction

   // Pads the message, appends the bit length and returns the digest words.
   function automatic logic [3:0][31:0] md5_finish();
      logic [3:0][31:0] dg;
      logic [63:0] len;
      int pos;
      len = bit_len;
      pos = int'(bit_len[8:3]);
      blk_bytes[pos] = 8'h80;
      pos = pos + 1;
      if (pos > 56) begin
         while (pos < 64) begin
            blk_bytes[pos] = 8'h00;
            pos = pos + 1;
         end
         md5_compress();
         pos = 0;
      end
      while (pos < 56) begin
         blk_bytes[pos] = 8'h00;
         pos = pos + 1;
      end
      for (int k = 0; k < 8; k++)
         blk_bytes[56 + k] = len[8*k +: 8];
      md5_compress();
      for (int k = 0; k < 4; k++)
         dg[k] = chain[k];
      chain_reset();
      return dg;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic set_mode(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 51;
            rsp_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            rsp_stall_pct = 51;
         end
         default: begin
            send_idle_pct = 26;
            rsp_stall_pct = 26;
         end
      endcase
   endtask

   // Called and returns at a falling edge; the caller decides what valid does next.
   task automatic offer(input logic [7:0] data, input logic has_byte, input logic is_end,
                        input logic typed, input logic [3:0][31:0] typed_digest);
      logic [3:0][31:0] dg;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_byte_valid <= has_byte;
      req_end_of_message <= is_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (has_byte) begin
         md5_absorb(data);
         bytes_sent++;
      end
      if (is_end) begin
         dg = md5_finish();
         if (typed)
            dg = typed_digest;
         for (int k = 0; k < 4; k++)
            digest_fifo.push_back('{dg[k], 2'(k), (k == 3)});
         messages_sent++;
      end
      if (has_byte || is_end)
         items_sent++;
      else
         ignored_items++;
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (digest_fifo.size() != 0);
   endtask

   task automatic send_message(input int len);
      logic joint;
      joint = (len > 0) && ($urandom_range(1) == 1);
      for (int n = 0; n < len; n++) begin
         if ($urandom_range(99) < 8)
            offer(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
         offer(8'($urandom), 1'b1, joint && (n == len - 1), 1'b0, '0);
      end
      if (!joint)
         offer(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
   endtask

   // Result side: random stall, or a long hold-off when the stimulus asks for one.
   always @(negedge clock) begin
      if (hold_asked != hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = hold_asked;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      digest_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (digest_fifo.size() == 0) begin
            note_mismatch($sformatf("unexpected digest word %h index %0d final %0b",
                                    rsp_digest_word, rsp_word_index, rsp_final_word));
         end else begin
            want = digest_fifo.pop_front();
            if (rsp_digest_word !== want.word || rsp_word_index !== want.idx ||
                rsp_final_word !== want.fin)
               note_mismatch($sformatf("expected word %h index %0d final %0b, got %h %0d %0b",
                                       want.word, want.idx, want.fin, rsp_digest_word,
                                       rsp_word_index, rsp_final_word));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d digest words outstanding.",
                  cycle_count, digest_fifo.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int len, pick, rest;
      chain_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_mode(0);
      for (int i = 0; i < DIRECTED_ROWS; i++)
         offer(DIRECTED[i].data, DIRECTED[i].has_byte, DIRECTED[i].is_end,
               DIRECTED[i].typed, DIRECTED[i].digest);
      pause_until_drained();

      for (int m = 0; items_sent + ignored_items < RANDOM_ITEMS || m < MIN_MESSAGES; m++) begin
         set_mode(m % 4);
         // The held-off result side backs up into the next message.
         if (m == 5)
            hold_asked++;
         if (m % 6 == 3)
            pause_until_drained();
         pick = $urandom_range(99);
         if (pick < 60)
            len = $urandom_range(0, 12);
         else if (pick < 85)
            len = EDGE_LEN[$urandom_range(0, 8)];
         else
            len = $urandom_range(13, 130);
         // A short message during the hold-off ends early enough to fill the block.
         if (m == 5)
            len = $urandom_range(0, 12);
         rest = RANDOM_ITEMS - items_sent - ignored_items;
         if (len > rest)
            len = (rest > 0) ? rest : 0;
         send_message(len);
      end
      req_valid <= 1'b0;

      while (digest_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Hashed %0d messages from %0d bytes (%0d ignored items) under four idling modes,",
               messages_sent, bytes_sent, ignored_items);
      $display("checking %0d digest words with %0d mismatches.", words_checked, mismatches);
      if (mismatches == 0 && digest_fifo.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
